@@ sv/drat_literal_varint_encoder_defines.svh @@
// Assertion macros used by the varint encoder controller.
`ifndef DRAT_LITERAL_VARINT_ENCODER_DEFINES_SVH
`define DRAT_LITERAL_VARINT_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define DLVE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("dlve assertion failed");

// Checks that an expression is never true outside reset.
`define DLVE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `DLVE_ASSERT(lbl, clk, rst_n, !(expr))

`else

`define DLVE_ASSERT(lbl, clk, rst_n, prop)
`define DLVE_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

@@ sv/dlve_pkg.sv @@
// Shared types and constants of the DRAT literal varint encoder.
package dlve_pkg;

    localparam int LIT_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int GROUP_BITS = 7;

    localparam logic [LIT_W-1:0] SIGN_FLIP = LIT_W'(1);

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

@@ sv/dlve_dp.sv @@
// Datapath of the varint encoder: the value register and the output byte.
module dlve_dp
    import dlve_pkg::*;
(
    input  logic              i_clk,
    input  t_dp_cmd           i_cmd,
    input  logic [LIT_W-1:0]  i_literal,
    output t_dp_status        o_status,
    output logic [BYTE_W-1:0] o_byte
);

    logic [LIT_W-1:0] r_value;
    logic [LIT_W-1:0] n_value;
    logic             rest_zero;

    // The sign bit is inverted on load so positive literals carry a 0.
    always_comb begin
        n_value = r_value;
        if (i_cmd.load) begin
            n_value = i_literal ^ SIGN_FLIP;
        end else if (i_cmd.shift) begin
            n_value = r_value >> GROUP_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign rest_zero       = (r_value[LIT_W-1:GROUP_BITS] == '0);
    assign o_status.last   = rest_zero;
    assign o_byte          = {~rest_zero, r_value[GROUP_BITS-1:0]};

endmodule

@@ sv/dlve_ctrl.sv @@
// Controller of the varint encoder: handshakes and datapath sequencing.
`include "drat_literal_varint_encoder_defines.svh"

module dlve_ctrl
    import dlve_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   out_xfer;
    logic   in_xfer;

    assign o_out_valid = (r_state == ST_EMIT);
    assign out_xfer    = o_out_valid & i_out_ready;
    // A new literal may be taken in the cycle the final byte leaves.
    assign o_in_ready  = (r_state == ST_IDLE) | (out_xfer & i_status.last);
    assign in_xfer     = i_in_valid & o_in_ready;

    assign o_cmd.load  = in_xfer;
    assign o_cmd.shift = out_xfer & ~i_status.last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_xfer && i_status.last && !in_xfer) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `DLVE_ASSERT_NEVER(a_load_shift_excl, i_clk, i_rst_n, o_cmd.load && o_cmd.shift)
    `DLVE_ASSERT(a_shift_not_last, i_clk, i_rst_n, o_cmd.shift |-> !i_status.last)
    `DLVE_ASSERT(a_done_to_idle, i_clk, i_rst_n,
        (out_xfer && i_status.last && !in_xfer) |=> !o_out_valid)
    `DLVE_ASSERT(a_load_to_emit, i_clk, i_rst_n, o_cmd.load |=> o_out_valid)

endmodule

@@ sv/drat_literal_varint_encoder.sv @@
// Top level of the binary DRAT literal varint encoder.
//
// The slave channel takes one 32-bit raw solver literal per transfer; bit 0
// is the sign with 1 meaning positive. The block inverts that bit and sends
// the result as an unsigned little-endian base-128 varint on the master
// channel, one byte per transfer, least significant 7-bit group first.
// Bit 7 of each byte is set when more bytes follow, and tlast marks the
// final byte of each literal.
// A literal produces one to five bytes. The first byte is presented in the
// cycle after the literal's transfer, and each further byte follows once the
// previous one leaves, since the single value register is shifted by seven
// bits per byte.
// The next literal is accepted in the same cycle as the previous literal's
// final byte transfer, so back-to-back five-byte literals run at one byte
// per cycle while the receiver is ready. When the receiver stalls, the
// current byte holds and no new literal is accepted until the final byte
// has gone. Reset returns the controller to idle with no byte pending.
module drat_literal_varint_encoder
    import dlve_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Slave channel.
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [LIT_W-1:0]  i_s_tdata,   // [31:0] raw_literal
    // Master channel.
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [BYTE_W-1:0] o_m_tdata,   // [7:0] out_byte
    output logic              o_m_tlast    // last_byte
);

    t_dp_cmd    cmd;
    t_dp_status status;

    dlve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dlve_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_literal (i_s_tdata),
        .o_status  (status),
        .o_byte    (o_m_tdata)
    );

    // The final byte is the one with no payload bits left above it.
    assign o_m_tlast = status.last;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the binary DRAT literal varint encoder.
`timescale 1ns / 100ps

module tb_top;
    import dlve_pkg::*;

    // One encoded byte as it should leave the master channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_varint_byte;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [LIT_W-1:0]  i_s_tdata = '0;   // [31:0] raw_literal
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [BYTE_W-1:0] o_m_tdata;        // [7:0] out_byte
    logic              o_m_tlast;        // last_byte

    // Bytes the encoder still owes us, oldest first.
    t_varint_byte expected_bytes[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int literals_sent = 0;
    int bytes_checked = 0;
    int failures = 0;

    drat_literal_varint_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver stalls at random, at the rate set for the current phase.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Flips the sign bit and splits the value into 7-bit groups, least
    // significant first, with the continuation bit set on all but the last.
    function automatic void predict_varint(input logic [LIT_W-1:0] raw);
        logic [LIT_W-1:0] value;
        logic [LIT_W-1:0] rest;
        t_varint_byte     nb;
        int               count;
        value = raw ^ SIGN_FLIP;
        count = 0;
        do begin
            rest = value >> GROUP_BITS;
            nb.data = {(rest != '0), value[GROUP_BITS-1:0]};
            nb.last = (rest == '0);
            expected_bytes.push_back(nb);
            value = rest;
            count++;
        end while (value != '0 && count < 5);
    endfunction

    // Inputs only change at rising edges, so the values seen at the falling
    // edge are the ones the next rising edge acts on.
    always @(negedge i_clk) begin : byte_check
        t_varint_byte want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte transfer: out_byte=0x%02h last_byte=%0b",
                       o_m_tdata, o_m_tlast);
                failures++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_m_tdata !== want.data) begin
                    $error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
                           want.data, o_m_tdata);
                    failures++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_byte mismatch: expected %0b, actual %0b",
                           want.last, o_m_tlast);
                    failures++;
                end
                bytes_checked++;
            end
        end
    end

    // Called at a rising edge and returns at the rising edge of the transfer.
    // tvalid stays high on return so that back-to-back literals never lower
    // and raise it in the same step; drain_encoder lowers it.
    task automatic send_literal(input logic [LIT_W-1:0] raw);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= raw;
        do @(negedge i_clk); while (!o_s_tready);
        predict_varint(raw);
        literals_sent++;
        @(posedge i_clk);
    endtask

    // Waits until every predicted byte has been seen, then idles on so that a
    // stray extra byte would still show up in the current phase.
    task automatic drain_encoder();
        i_s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // A random literal; half of them are narrowed so that every byte count
    // from one to five turns up often.
    function automatic logic [LIT_W-1:0] random_literal();
        logic [63:0] mask;
        int          width;
        if ($urandom_range(1) == 0) begin
            return $urandom();
        end
        width = $urandom_range(LIT_W, 1);
        mask = (64'd1 << width) - 64'd1;
        return $urandom() & mask[LIT_W-1:0];
    endfunction

    // Sign handling: zero after the flip, both signs of small and huge values.
    task automatic test_sign_flip();
        send_literal(32'h0000_0001);
        send_literal(32'h0000_0000);
        send_literal(32'h0000_0002);
        send_literal(32'h0000_0003);
        send_literal(32'hFFFF_FFFF);
        send_literal(32'hFFFF_FFFE);
        send_literal(32'h8000_0000);
        send_literal(32'h8000_0001);
        send_literal(32'hAAAA_AAAA);
        send_literal(32'h5555_5555);
        drain_encoder();
    endtask

    // Each 7-bit group boundary, just below and at the point where one more
    // byte is needed, measured on the flipped value.
    task automatic test_group_boundaries();
        logic [LIT_W-1:0] edge_value;
        for (int k = 1; k <= 4; k++) begin
            edge_value = 32'd1 << (GROUP_BITS * k);
            send_literal((edge_value - 32'd1) ^ SIGN_FLIP);
            send_literal(edge_value ^ SIGN_FLIP);
        end
        send_literal(32'h7FFF_FFFF);
        send_literal(32'h7FFF_FFFE);
        drain_encoder();
    endtask

    // Random literals under one setting of sender gaps and receiver stalls.
    task automatic test_random_literals(input int idle_pct, input int stall_pct,
                                        input int count);
        send_idle_pct  <= idle_pct;
        recv_stall_pct <= stall_pct;
        @(posedge i_clk);
        repeat (count) send_literal(random_literal());
        drain_encoder();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_sign_flip();
        test_group_boundaries();
        test_random_literals(0, 0, 100);
        test_random_literals(74, 0, 100);
        test_random_literals(0, 74, 100);
        test_random_literals(35, 35, 100);

        if (expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            failures++;
        end
        $display("Encoded %0d literals into %0d checked bytes, covering sign flips,",
                 literals_sent, bytes_checked);
        $display("every group boundary and random values under four gap/stall mixes.");
        if (failures == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
